// ===== rtl/retransmit_timer_table_assert.svh =====
// Assertion macros used by the retransmit timer table checker.
// Depends on nothing; included by the checker file.
`ifndef RETRANSMIT_TIMER_TABLE_ASSERT_SVH
`define RETRANSMIT_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rtt_pkg.sv =====
// Shared types and constants of the retransmit timer table.
// No dependencies; used by every other file of the block but the assertion header.
package rtt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SEQ_W  = 16;
  localparam int AGE_W  = 16;
  localparam int CMD_W  = 3;

  localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_ACK   = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_CHECK = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  // Item travelling down the cell chain, with what it has gathered so far.
  typedef struct packed {
    logic              active;
    logic [CMD_W-1:0]  cmd;
    logic [SEQ_W-1:0]  seq;
    logic              matched;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              best_found;
    logic [SEQ_W-1:0]  best_seq;
    logic              any_valid;
  } token_t;

  // Slot fill at the end of an add.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [SEQ_W-1:0]  seq;
  } slot_wr_t;

endpackage

// ===== rtl/rtt_in_if.sv =====
// Command channel of the retransmit timer table: valid/ready plus payload.
// Depends on rtt_pkg for field widths.
interface rtt_in_if;
  logic                        valid;
  logic                        ready;
  logic [rtt_pkg::CMD_W-1:0]   command;
  logic [rtt_pkg::SEQ_W-1:0]   seq;

  modport source (output valid, output command, output seq, input ready);
  modport sink   (input valid, input command, input seq, output ready);
endinterface

// ===== rtl/rtt_out_if.sv =====
// Result channel of the retransmit timer table: valid/ready plus payload.
// Depends on rtt_pkg for field widths.
interface rtt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found_expired;
  logic [rtt_pkg::SEQ_W-1:0]   expired_seq;
  logic                        timeout_seen;
  logic                        table_empty;
  logic                        add_dropped;

  modport source (output valid, output found_expired, output expired_seq,
                  output timeout_seen, output table_empty, output add_dropped,
                  input ready);
  modport sink   (input valid, input found_expired, input expired_seq,
                  input timeout_seen, input table_empty, input add_dropped,
                  output ready);
endinterface

// ===== rtl/rtt_cell.sv =====
// One timer slot of the chain: holds valid, seq and age, updates them as the
// item passes, and hands the item to the next cell. Depends on rtt_pkg.
module rtt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [rtt_pkg::SLOT_W-1:0]  slot_idx,
  input  logic [rtt_pkg::AGE_W-1:0]   timeout,
  input  rtt_pkg::slot_wr_t           wr,
  input  rtt_pkg::token_t             tok_in,
  output rtt_pkg::token_t             tok_out
);

  logic                       valid_r, valid_nxt;
  logic [rtt_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic [rtt_pkg::AGE_W-1:0]  age_r, age_nxt;
  rtt_pkg::token_t            tok_r, tok_nxt;
  logic                       hit;
  logic                       wr_hit;

  assign hit    = valid_r && (seq_r == tok_in.seq);
  assign wr_hit = wr.en && (wr.idx == slot_idx);

  always_comb begin
    valid_nxt = valid_r;
    seq_nxt   = seq_r;
    age_nxt   = age_r;
    tok_nxt   = tok_in;
    if (tok_in.active) begin
      case (tok_in.cmd)
        rtt_pkg::CMD_ADD: begin
          if (hit) tok_nxt.matched = 1'b1;
          // take the first free slot seen along the chain
          if (!valid_r && !tok_in.free_found) begin
            tok_nxt.free_found = 1'b1;
            tok_nxt.free_idx   = slot_idx;
          end
        end
        rtt_pkg::CMD_ACK: begin
          if (hit) valid_nxt = 1'b0;
        end
        rtt_pkg::CMD_TICK: begin
          if (valid_r && (age_r < timeout)) age_nxt = age_r + 1'b1;
        end
        rtt_pkg::CMD_CHECK: begin
          if (valid_r && (age_r >= timeout) &&
              (!tok_in.best_found || (seq_r < tok_in.best_seq))) begin
            tok_nxt.best_found = 1'b1;
            tok_nxt.best_seq   = seq_r;
          end
        end
        rtt_pkg::CMD_CLEAR: begin
          valid_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      tok_nxt.any_valid = tok_in.any_valid | valid_nxt;
    end
    if (wr_hit) begin
      valid_nxt = 1'b1;
      seq_nxt   = wr.seq;
      age_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else if (advance) begin
      valid_r      <= valid_nxt;
      tok_r.active <= tok_nxt.active;
    end
    if (advance) begin
      seq_r              <= seq_nxt;
      age_r              <= age_nxt;
      tok_r.cmd          <= tok_nxt.cmd;
      tok_r.seq          <= tok_nxt.seq;
      tok_r.matched      <= tok_nxt.matched;
      tok_r.free_found   <= tok_nxt.free_found;
      tok_r.free_idx     <= tok_nxt.free_idx;
      tok_r.best_found   <= tok_nxt.best_found;
      tok_r.best_seq     <= tok_nxt.best_seq;
      tok_r.any_valid    <= tok_nxt.any_valid;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/retransmit_timer_table.sv =====
// Top level of the retransmit timer table: the cell chain, the add fill,
// the result register and the timeout register. Depends on rtt_pkg,
// rtt_in_if, rtt_out_if and rtt_cell.
//
// Usage:
//   in_ch carries one command item (add, acknowledge, tick, check, clear)
//   with a sequence number; out_ch returns exactly one result item for it.
//   cfg_we/cfg_wdata write timeout_r; write it only while no item is
//   in flight.
//   Each item walks the chain of SLOTS cells, one cell per cycle while the chain
//   is not frozen, and its result is then registered onto out_ch. One item is
//   in the chain at a time: in_ch.ready is low from acceptance until the item
//   leaves the last cell.
//   A result waits in the output register while out_ch.ready is low; if the
//   next item reaches the end of the chain meanwhile, the chain freezes until
//   the register frees up.
//   Reset empties every slot, drops the sticky timeout flag and sets the
//   timeout to 100 ticks; no clearing pass is needed.
module retransmit_timer_table (
  input  logic                        clk,
  input  logic                        rst_n,
  rtt_in_if.sink                      in_ch,
  rtt_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [rtt_pkg::AGE_W-1:0]   cfg_wdata
);

  localparam int N = rtt_pkg::SLOTS;

  rtt_pkg::token_t            tok_q [N];
  rtt_pkg::token_t            inject;
  rtt_pkg::token_t            last;
  rtt_pkg::slot_wr_t          wr;

  logic [rtt_pkg::AGE_W-1:0]  timeout_r;
  logic                       busy_r, busy_nxt;
  logic                       latched_r, latched_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       found_r, found_nxt;
  logic [rtt_pkg::SEQ_W-1:0]  eseq_r, eseq_nxt;
  logic                       empty_r, empty_nxt;
  logic                       dropped_r, dropped_nxt;

  logic advance;
  logic accept;
  logic done;
  logic is_add;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;

  always_comb begin
    inject            = '0;
    inject.active     = accept;
    inject.cmd        = in_ch.command;
    inject.seq        = in_ch.seq;
  end

  assign last    = tok_q[N-1];
  // freeze the chain while a finished item cannot enter the output register
  assign advance = !(last.active && out_valid_r && !out_ch.ready);
  assign done    = last.active && advance;
  assign is_add  = (last.cmd == rtt_pkg::CMD_ADD);

  always_comb begin
    wr.en  = done && is_add && !last.matched && last.free_found;
    wr.idx = last.free_idx;
    wr.seq = last.seq;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    rtt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .slot_idx (rtt_pkg::SLOT_W'(i)),
      .timeout  (timeout_r),
      .wr       (wr),
      .tok_in   ((i == 0) ? inject : tok_q[(i == 0) ? 0 : i-1]),
      .tok_out  (tok_q[i])
    );
  end

  always_comb begin
    found_nxt   = found_r;
    eseq_nxt    = eseq_r;
    empty_nxt   = empty_r;
    dropped_nxt = dropped_r;
    latched_nxt = latched_r;
    if (done) begin
      found_nxt   = (last.cmd == rtt_pkg::CMD_CHECK) && last.best_found;
      eseq_nxt    = found_nxt ? last.best_seq : '0;
      dropped_nxt = is_add && !last.matched && !last.free_found;
      empty_nxt   = !(last.any_valid || wr.en);
      if (last.cmd == rtt_pkg::CMD_CLEAR) latched_nxt = 1'b0;
      else if (found_nxt)                 latched_nxt = 1'b1;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (accept)       busy_nxt = 1'b1;
    else if (done)    busy_nxt = 1'b0;
    if (done)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= rtt_pkg::TIMEOUT_RST;
      busy_r      <= 1'b0;
      latched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      busy_r      <= busy_nxt;
      latched_r   <= latched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r   <= found_nxt;
    eseq_r    <= eseq_nxt;
    empty_r   <= empty_nxt;
    dropped_r <= dropped_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found_expired = found_r;
  assign out_ch.expired_seq   = eseq_r;
  assign out_ch.timeout_seen  = latched_r;
  assign out_ch.table_empty   = empty_r;
  assign out_ch.add_dropped   = dropped_r;

endmodule

// ===== rtl/rtt_checker.sv =====
// Port-level checker for the retransmit timer table, bound to the top level.
// Depends on rtt_pkg and the macros in retransmit_timer_table_assert.svh.
`include "retransmit_timer_table_assert.svh"

module rtt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        found_expired,
  input logic [rtt_pkg::SEQ_W-1:0]   expired_seq,
  input logic                        timeout_seen,
  input logic                        table_empty,
  input logic                        add_dropped
);

  logic [rtt_pkg::SEQ_W+4-1:0] out_bus;

  assign out_bus = {found_expired, expired_seq, timeout_seen, table_empty, add_dropped};

  // a found timer is held, so the table cannot be empty and the flag is set
  `RTT_ASSERT_IMP(a_found_sets_flag, clk, rst_n, out_valid && found_expired,
                  timeout_seen && !table_empty)
  `RTT_ASSERT_IMP(a_seq_zero_if_none, clk, rst_n, out_valid && !found_expired,
                  expired_seq == '0)
  // a dropped add means every slot is in use
  `RTT_ASSERT_IMP(a_drop_not_empty, clk, rst_n, out_valid && add_dropped,
                  !table_empty && !found_expired)
  `RTT_ASSERT_NXT(a_hold_on_stall, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(out_bus))

endmodule

bind retransmit_timer_table rtt_checker u_rtt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .found_expired (out_ch.found_expired),
  .expired_seq   (out_ch.expired_seq),
  .timeout_seen  (out_ch.timeout_seen),
  .table_empty   (out_ch.table_empty),
  .add_dropped   (out_ch.add_dropped)
);
